>>> src/boxiou_pkg.sv
// Package for box_intersection_over_union: field widths and transaction types.
package boxiou_pkg;

  // Pixel coordinate and size width, and fraction bits of the overlap ratio
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;

  localparam int AREA_BITS  = 2 * COORD_BITS;
  localparam int UNION_BITS = AREA_BITS + 1;
  localparam int RATIO_BITS = FRAC_BITS + 1;

  localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1) << FRAC_BITS;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t box_a_x;
    coord_t box_a_y;
    coord_t box_a_width;
    coord_t box_a_height;
    coord_t box_b_x;
    coord_t box_b_y;
    coord_t box_b_width;
    coord_t box_b_height;
  } boxiou_in_t;

  typedef struct packed {
    logic [RATIO_BITS-1:0] overlap_ratio;
    logic                  empty_union;
  } boxiou_out_t;

endpackage

>>> src/box_intersection_over_union.sv
// Top level: pipelined intersection over union of two axis-aligned boxes.
// Depth: 3 + FRAC_BITS + 1 register stages (20 at FRAC_BITS = 16).
// Throughput: one transaction per cycle while in_stall is low; each stage advances
//   on its own, so bubbles collapse and in_stall rises only once all stages hold data.
// Reset: synchronous, active low rst_n clears every stage valid bit; payload is not reset.
module box_intersection_over_union (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  boxiou_pkg::boxiou_in_t   in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output boxiou_pkg::boxiou_out_t  out_data
);

  localparam int CB = boxiou_pkg::COORD_BITS;
  localparam int AB = boxiou_pkg::AREA_BITS;
  localparam int UB = boxiou_pkg::UNION_BITS;
  localparam int QB = boxiou_pkg::RATIO_BITS;
  localparam int FB = boxiou_pkg::FRAC_BITS;

  // Stage map: overlap lengths, products, union, then one quotient bit per stage.
  localparam int S_OVL   = 0;
  localparam int S_AREA  = 1;
  localparam int S_UNION = 2;
  localparam int S_DIV0  = 3;
  localparam int NSTG    = S_DIV0 + FB + 1;
  localparam int NDIV    = FB + 1;

  // ---------------------------------------------------------------------------
  // Flow control: a stage may load when it is empty or some stage after it is
  // empty, or when the output is being taken. Written in parallel form rather
  // than as a ripple through every stage.
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] rdy;

  always_comb begin
    logic [NSTG-1:0] low_mask;
    low_mask = '0;
    for (int i = 0; i < NSTG; i++) begin
      low_mask = NSTG'((64'd1 << i) - 64'd1);
      rdy[i]   = !out_stall || ((vld_r | low_mask) != {NSTG{1'b1}});
    end
  end

  always_comb begin
    for (int i = 0; i < NSTG; i++) begin
      if (rdy[i]) begin
        vld_nxt[i] = (i == 0) ? in_valid : vld_r[(i == 0) ? 0 : i - 1];
      end else begin
        vld_nxt[i] = vld_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall = !rdy[S_OVL];

  // ---------------------------------------------------------------------------
  // Stage 1: clip the overlap on each axis. Far edges are one bit wider so they
  // never wrap; the overlap never exceeds the narrower box, so it fits CB bits.
  // ---------------------------------------------------------------------------
  logic [CB-1:0] ovl_x_r, ovl_y_r, aw_r, ah_r, bw_r, bh_r;
  logic [CB-1:0] ovl_x_nxt, ovl_y_nxt;

  function automatic logic [CB-1:0] overlap_len(
    input logic [CB-1:0] s0, input logic [CB-1:0] l0,
    input logic [CB-1:0] s1, input logic [CB-1:0] l1
  );
    logic [CB:0] lo;
    logic [CB:0] hi;
    logic [CB:0] e0;
    logic [CB:0] e1;
    logic [CB:0] diff;
    e0   = {1'b0, s0} + {1'b0, l0};
    e1   = {1'b0, s1} + {1'b0, l1};
    lo   = (s0 > s1) ? {1'b0, s0} : {1'b0, s1};
    hi   = (e0 < e1) ? e0 : e1;
    diff = hi - lo;
    return (hi > lo) ? diff[CB-1:0] : '0;
  endfunction

  always_comb begin
    ovl_x_nxt = overlap_len(in_data.box_a_x, in_data.box_a_width,
                            in_data.box_b_x, in_data.box_b_width);
    ovl_y_nxt = overlap_len(in_data.box_a_y, in_data.box_a_height,
                            in_data.box_b_y, in_data.box_b_height);
  end

  always_ff @(posedge clk) begin
    if (rdy[S_OVL]) begin
      ovl_x_r <= ovl_x_nxt;
      ovl_y_r <= ovl_y_nxt;
      aw_r    <= in_data.box_a_width;
      ah_r    <= in_data.box_a_height;
      bw_r    <= in_data.box_b_width;
      bh_r    <= in_data.box_b_height;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: three independent CB x CB products.
  // ---------------------------------------------------------------------------
  logic [AB-1:0] inter_r, area_a_r, area_b_r;

  always_ff @(posedge clk) begin
    if (rdy[S_AREA]) begin
      inter_r  <= AB'(ovl_x_r) * AB'(ovl_y_r);
      area_a_r <= AB'(aw_r) * AB'(ah_r);
      area_b_r <= AB'(bw_r) * AB'(bh_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: union area. The intersection never exceeds either area, so the
  // difference cannot go negative.
  // ---------------------------------------------------------------------------
  logic [UB-1:0] union_r;
  logic [AB-1:0] inter2_r;
  logic [UB-1:0] union_nxt;

  assign union_nxt = UB'(area_a_r) + UB'(area_b_r) - UB'(inter_r);

  always_ff @(posedge clk) begin
    if (rdy[S_UNION]) begin
      union_r  <= union_nxt;
      inter2_r <= inter_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: restoring division, one quotient bit per stage. The intersection
  // is at most the union, so the top (integer) bit is set only for identical
  // boxes or an empty union, and for a nonempty union the remainder stays below the divisor.
  // ---------------------------------------------------------------------------
  logic [UB-1:0] rem_r   [NDIV];
  logic [QB-1:0] quo_r   [NDIV];
  logic [UB-1:0] dvs_r   [NDIV];
  logic          empty_r [NDIV];
  logic [UB-1:0] rem_nxt [NDIV];
  logic [QB-1:0] quo_nxt [NDIV];

  always_comb begin
    logic          ge0;
    logic [UB:0]   sh;
    logic [UB:0]   sub;
    logic          ge;
    ge0 = UB'(inter2_r) >= union_r;
    rem_nxt[0] = ge0 ? (UB'(inter2_r) - union_r) : UB'(inter2_r);
    quo_nxt[0] = QB'(ge0);
    sh  = '0;
    sub = '0;
    ge  = 1'b0;
    for (int d = 1; d < NDIV; d++) begin
      sh         = {rem_r[d-1], 1'b0};
      sub        = sh - {1'b0, dvs_r[d-1]};
      ge         = sh >= {1'b0, dvs_r[d-1]};
      rem_nxt[d] = ge ? sub[UB-1:0] : sh[UB-1:0];
      quo_nxt[d] = {quo_r[d-1][QB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < NDIV; d++) begin
      if (rdy[S_DIV0 + d]) begin
        rem_r[d]   <= rem_nxt[d];
        quo_r[d]   <= quo_nxt[d];
        dvs_r[d]   <= (d == 0) ? union_r : dvs_r[(d == 0) ? 0 : d - 1];
        empty_r[d] <= (d == 0) ? (union_r == '0) : empty_r[(d == 0) ? 0 : d - 1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output: the last divider stage is the output register. Force the ratio to
  // zero for an empty union.
  // ---------------------------------------------------------------------------
  assign out_valid              = vld_r[NSTG-1];
  assign out_data.empty_union   = empty_r[NDIV-1];
  assign out_data.overlap_ratio = empty_r[NDIV-1] ? '0 : quo_r[NDIV-1];

endmodule

>>> src/boxiou_checker.sv
// Port-level checker for box_intersection_over_union and its bind statement.
module boxiou_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input boxiou_pkg::boxiou_out_t out_data
);

  // With no result at the output, the pipeline always takes a transaction
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("in_stall high while no result is pending");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Empty union forces a zero ratio
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_union |-> out_data.overlap_ratio == '0)
    else $error("nonzero ratio with empty union");

  // Ratio never exceeds one
  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.overlap_ratio <= boxiou_pkg::RATIO_ONE)
    else $error("overlap ratio above one");

  // Nothing leaves straight after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind box_intersection_over_union boxiou_checker u_boxiou_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
